/* rtl/srrw_pkg.sv */
package srrw_pkg;
   localparam int WINDOW_SLOTS_DEF = 64;
   localparam int SLOT_BYTES_DEF = 1000;
   localparam int MAX_REQS = 64;
   localparam int REQ_LEN_W = 10;
   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_PAYLOAD = 2'd1;
   localparam logic [1:0] CMD_DRAIN = 2'd2;
   localparam logic [1:0] CMD_SCAN = 2'd3;
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_REQUEST = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [0:0] REG_TOTAL_BYTES = 1'd0;
endpackage

/* rtl/srrw_req_if.sv */
interface srrw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] seg_position;
   logic [15:0] seg_length;
   logic [7:0]  data_byte;
   modport source (output valid, cmd, seg_position, seg_length, data_byte, input ready);
   modport sink (input valid, cmd, seg_position, seg_length, data_byte, output ready);
endinterface

/* rtl/srrw_rsp_if.sv */
interface srrw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  out_byte;
   logic [31:0] req_start;
   logic [9:0]  req_length;
   logic        last_of_run;
   logic        all_done;
   modport source (output valid, kind, out_byte, req_start, req_length, last_of_run,
                   all_done, input ready);
   modport sink (input valid, kind, out_byte, req_start, req_length, last_of_run,
                 all_done, output ready);
endinterface

/* rtl/selective_repeat_receive_window_top.sv */
// Channel   Dir  Beat
// req       in   cmd, seg_position, seg_length, data_byte
// rsp       out  kind, out_byte, req_start, req_length, last_of_run, all_done
// csr       in   APB write of total_bytes at address 0
// A payload beat and a dropped header are handled in S_IDLE. An accepted header then walks its
// slot offset in S_HDIV one slot per cycle, stopping after WINDOW_SLOTS slots or at total_bytes.
// A drain steps through accept, fill and byte memory read, and result load.
// A scan walks the slots from the head slot and emits its requests one request behind.
// Reset is synchronous; it clears control state and the slot valid bits, not the memories.
// A full result register stalls a drain in S_DBYTE, and a scan holding a request at its next hit or run end.
module selective_repeat_receive_window_top #(
   parameter int WINDOW_SLOTS = srrw_pkg::WINDOW_SLOTS_DEF,
   parameter int SLOT_BYTES = srrw_pkg::SLOT_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   srrw_req_if.sink    req,
   srrw_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int SW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int FW = $clog2(SLOT_BYTES + 1);
   localparam int CW = $clog2(WINDOW_SLOTS + 1);
   localparam int LW = srrw_pkg::REQ_LEN_W;
   localparam int DEPTH = WINDOW_SLOTS * SLOT_BYTES;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [32:0] SB33 = 33'(SLOT_BYTES);

   typedef enum logic [2:0] {
      S_IDLE, S_HDIV, S_DRD, S_DBYTE, S_SCAN
   } state_type;

   state_type state_ff;
   logic [31:0] total_ff;
   logic [WINDOW_SLOTS-1:0] fvalid_ff;
   logic [FW-1:0] fill_mem [WINDOW_SLOTS];
   logic [7:0] store_mem [DEPTH];
   logic [FW-1:0] fill_rd_ff;
   logic [7:0] byte_rd_ff;
   logic [SW-1:0] head_ff, wslot_ff, scan_slot_ff;
   logic [31:0] dlv_ff, rem_ff;
   logic [32:0] base_ff, scan_st_ff;
   logic [FW-1:0] rd_idx_ff;
   logic [FW-1:0] wcnt_ff, wlen_ff;
   logic wact_ff;
   logic [CW-1:0] ahead_ff, scan_i_ff;
   logic [6:0] cnt_ff;
   logic hold_ff;
   logic [31:0] hold_start_ff;
   logic [LW-1:0] hold_len_ff;
   logic pend_ff, pend_last_ff;
   logic [1:0] pend_kind_ff;
   logic [7:0] pend_byte_ff;
   logic [31:0] pend_start_ff;
   logic [LW-1:0] pend_len_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = total_ff;
   wire csr_wr = csr_psel && csr_penable && csr_pwrite &&
                 csr_paddr[1:0] == {srrw_pkg::REG_TOTAL_BYTES, 1'b0};
   always_ff @(posedge clock) begin
      if (reset) total_ff <= '0;
      else if (csr_wr) total_ff <= csr_pwdata;
   end

   wire done = dlv_ff >= total_ff;
   wire in_acc = req.valid && req.ready;
   wire out_free = !pend_ff || rsp.ready;
   wire [SW:0] slot_sum = {1'b0, head_ff} + (SW+1)'(ahead_ff);
   wire [SW-1:0] hslot = (slot_sum >= (SW+1)'(WINDOW_SLOTS)) ?
                         SW'(slot_sum - (SW+1)'(WINDOW_SLOTS)) : slot_sum[SW-1:0];
   wire [32:0] srem = {1'b0, total_ff} - scan_st_ff;
   wire [LW-1:0] slen = (srem >= SB33) ? LW'(SLOT_BYTES) : srem[LW-1:0];
   wire [SW-1:0] slot_nx = (scan_slot_ff == SW'(WINDOW_SLOTS - 1)) ? '0 : scan_slot_ff + 1'b1;
   wire [SW-1:0] head_nx = (head_ff == SW'(WINDOW_SLOTS - 1)) ? '0 : head_ff + 1'b1;
   wire [32:0] dlv_nx = {1'b0, dlv_ff} + SB33;
   wire [FW-1:0] wcnt_nx = wcnt_ff + 1'b1;
   wire [FW-1:0] rd_nx = rd_idx_ff + 1'b1;
   wire pay_wr = in_acc && req.cmd == srrw_pkg::CMD_PAYLOAD && wact_ff &&
                 wcnt_ff < FW'(SLOT_BYTES);
   wire pay_last = pay_wr && wcnt_nx >= wlen_ff;
   wire drain_ok = !done && fvalid_ff[head_ff] && rd_idx_ff < fill_rd_ff;
   wire drain_last = rd_nx >= fill_rd_ff;
   wire scan_end = scan_i_ff >= CW'(WINDOW_SLOTS) || scan_st_ff >= {1'b0, total_ff} ||
                   cnt_ff >= 7'(srrw_pkg::MAX_REQS);
   wire scan_hit = !fvalid_ff[scan_slot_ff];
   wire pend_load = out_free && (state_ff == S_DBYTE ||
                    (state_ff == S_SCAN && hold_ff && (scan_end || scan_hit)));
   wire [AW-1:0] rd_addr = AW'(32'(head_ff) * 32'(SLOT_BYTES) + 32'(rd_idx_ff));
   wire [AW-1:0] wr_addr = AW'(32'(wslot_ff) * 32'(SLOT_BYTES) + 32'(wcnt_ff));

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = pend_ff;
   assign rsp.kind = pend_kind_ff;
   assign rsp.out_byte = pend_byte_ff;
   assign rsp.req_start = pend_start_ff;
   assign rsp.req_length = pend_len_ff;
   assign rsp.last_of_run = pend_last_ff;
   assign rsp.all_done = done;

   // Both memories are read every cycle at the head slot and its read index.
   always_ff @(posedge clock) begin
      fill_rd_ff <= fill_mem[head_ff];
      byte_rd_ff <= store_mem[rd_addr];
      if (pay_wr) store_mem[wr_addr] <= req.data_byte;
      if (pay_last) fill_mem[wslot_ff] <= wlen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fvalid_ff <= '0;
         head_ff <= '0; dlv_ff <= '0; rd_idx_ff <= '0;
         wslot_ff <= '0; wcnt_ff <= '0; wlen_ff <= '0; wact_ff <= 1'b0;
         pend_ff <= 1'b0; pend_last_ff <= 1'b0; hold_ff <= 1'b0;
      end else begin
         pend_ff <= pend_load || (pend_ff && !rsp.ready);
         unique case (state_ff)
            S_IDLE: if (in_acc) begin
               unique case (req.cmd)
                  srrw_pkg::CMD_HEADER: begin
                     wact_ff <= 1'b0;
                     rem_ff <= req.seg_position - dlv_ff;
                     base_ff <= {1'b0, dlv_ff};
                     ahead_ff <= '0;
                     wlen_ff <= FW'(req.seg_length);
                     if (req.seg_length != '0 && 32'(req.seg_length) <= 32'(SLOT_BYTES) &&
                         req.seg_position >= dlv_ff)
                        state_ff <= S_HDIV;
                  end
                  srrw_pkg::CMD_PAYLOAD: begin
                     if (pay_wr) begin
                        wcnt_ff <= wcnt_nx;
                        if (pay_last) begin
                           fvalid_ff[wslot_ff] <= 1'b1;
                           wact_ff <= 1'b0;
                        end
                     end else wact_ff <= 1'b0;
                  end
                  srrw_pkg::CMD_DRAIN: state_ff <= S_DRD;
                  srrw_pkg::CMD_SCAN: begin
                     scan_i_ff <= '0; cnt_ff <= '0;
                     scan_slot_ff <= head_ff;
                     scan_st_ff <= {1'b0, dlv_ff};
                     state_ff <= S_SCAN;
                  end
               endcase
            end
            S_HDIV: begin
               // base_ff tracks the file offset of the slot reached so far.
               if (ahead_ff >= CW'(WINDOW_SLOTS) || base_ff >= {1'b0, total_ff}) begin
                  state_ff <= S_IDLE;
               end else if (rem_ff >= 32'(SLOT_BYTES)) begin
                  rem_ff <= rem_ff - 32'(SLOT_BYTES);
                  ahead_ff <= ahead_ff + 1'b1;
                  base_ff <= base_ff + SB33;
               end else begin
                  if (!fvalid_ff[hslot]) begin
                     wslot_ff <= hslot; wcnt_ff <= '0; wact_ff <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_DRD: state_ff <= S_DBYTE;
            S_DBYTE: if (out_free) begin
               if (drain_ok) begin
                  pend_kind_ff <= srrw_pkg::KIND_BYTE; pend_byte_ff <= byte_rd_ff;
                  if (drain_last) begin
                     fvalid_ff[head_ff] <= 1'b0;
                     rd_idx_ff <= '0;
                     head_ff <= head_nx;
                     dlv_ff <= dlv_nx[32] ? 32'hFFFF_FFFF : dlv_nx[31:0];
                  end else rd_idx_ff <= rd_nx;
               end else begin
                  pend_kind_ff <= srrw_pkg::KIND_EMPTY; pend_byte_ff <= '0;
               end
               pend_start_ff <= '0; pend_len_ff <= '0; pend_last_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            S_SCAN: begin
               // A found request is held until the next hit or the end of the run,
               // which tells whether it is the last one.
               if (scan_end) begin
                  if (!hold_ff) state_ff <= S_IDLE;
                  else if (out_free) begin
                     pend_kind_ff <= srrw_pkg::KIND_REQUEST; pend_byte_ff <= '0;
                     pend_start_ff <= hold_start_ff; pend_len_ff <= hold_len_ff;
                     pend_last_ff <= 1'b1;
                     hold_ff <= 1'b0;
                     state_ff <= S_IDLE;
                  end
               end else if (!scan_hit) begin
                  scan_i_ff <= scan_i_ff + 1'b1;
                  scan_slot_ff <= slot_nx;
                  scan_st_ff <= scan_st_ff + SB33;
               end else if (!hold_ff || out_free) begin
                  if (hold_ff) begin
                     pend_kind_ff <= srrw_pkg::KIND_REQUEST; pend_byte_ff <= '0;
                     pend_start_ff <= hold_start_ff; pend_len_ff <= hold_len_ff;
                     pend_last_ff <= 1'b0;
                  end
                  hold_ff <= 1'b1;
                  hold_start_ff <= scan_st_ff[31:0];
                  hold_len_ff <= slen;
                  cnt_ff <= cnt_ff + 1'b1;
                  scan_i_ff <= scan_i_ff + 1'b1;
                  scan_slot_ff <= slot_nx;
                  scan_st_ff <= scan_st_ff + SB33;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.kind) && $stable(rsp.out_byte) &&
         $stable(rsp.req_start) && $stable(rsp.req_length) && $stable(rsp.last_of_run));
   a_open_count: assert property (@(posedge clock) disable iff (reset)
      wact_ff |-> wcnt_ff < wlen_ff);
   a_read_head: assert property (@(posedge clock) disable iff (reset)
      rd_idx_ff != '0 |-> fvalid_ff[head_ff]);
   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.kind == srrw_pkg::KIND_BYTE || rsp.kind == srrw_pkg::KIND_REQUEST ||
         rsp.kind == srrw_pkg::KIND_EMPTY);
   a_last_request: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.last_of_run |-> rsp.kind == srrw_pkg::KIND_REQUEST);
`endif
endmodule
